// ===== hw/rtl/depth_pixel_backprojection_defines.svh =====
// Assertion macros used by the checker of the depth back-projection block.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Consequent must hold in the cycle of the antecedent.
`define DPB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depth_pixel_backprojection: check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define DPB_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("depth_pixel_backprojection: check failed");

`endif

// ===== hw/rtl/dpb_pkg.sv =====
package dpb_pkg;

   localparam int DPB_COORD_FRAC_BITS = 16;
   localparam int DPB_QUEUE_DEPTH = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_ADDR_W-1:0] REG_DEPTH_SCALE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_DEPTH      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FOCAL_LENGTHS  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OPTICAL_CENTER = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ROTATION_ROW0  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ROTATION_ROW1  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ROTATION_ROW2  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_TRANSLATION    = 3'd7;

   localparam logic [15:0] RST_DEPTH_SCALE    = 16'd5000;
   localparam logic [15:0] RST_MAX_DEPTH      = 16'd7000;
   localparam logic [39:0] RST_FOCAL_LENGTHS  = 40'd140928748800;
   localparam logic [39:0] RST_OPTICAL_CENTER = 40'd64290373504;
   localparam logic [53:0] RST_ROTATION_ROW0  = 54'd65536;
   localparam logic [53:0] RST_ROTATION_ROW1  = 54'd17179869184;
   localparam logic [53:0] RST_ROTATION_ROW2  = 54'd4503599627370496;
   localparam logic [59:0] RST_TRANSLATION    = 60'd0;

   localparam int DIV_NUM_W = 53;
   localparam int DIV_DEN_W = 36;
   localparam int DIV_Q_W = 43;
   localparam int DIV_SIDE_W = 2;
   localparam int CAM_W = 44;
   localparam logic [DIV_Q_W-1:0] CAM_LIMIT = 43'd1 << 42;

   localparam int DPB_LATENCY = DIV_Q_W + 8;

   typedef struct packed {
      logic [11:0] pixel_col;
      logic [11:0] pixel_row;
      logic [15:0] raw_depth;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic               point_valid;
      logic               last_point;
   } rsp_type;

   typedef struct packed {
      logic [15:0]             depth_scale;
      logic [15:0]             max_depth;
      logic [19:0]             fx;
      logic [19:0]             fy;
      logic [19:0]             cx;
      logic [19:0]             cy;
      logic [2:0][2:0][17:0]   rot;
      logic [2:0][19:0]        trans;
   } cfg_type;

   typedef struct packed {
      logic signed [CAM_W-1:0] cam_x;
      logic signed [CAM_W-1:0] cam_y;
      logic signed [CAM_W-1:0] cam_z;
      logic                    point_valid;
      logic                    last_point;
   } cam_type;

endpackage

// ===== hw/rtl/depth_pixel_backprojection.sv =====
// Depth pixel back-projection: turns one depth pixel into one world point.
// A transaction is taken at a rising edge where start is high and busy is
// low; req_data carries column, row, raw depth and the frame-end mark.
// Each pixel gives exactly one result on rsp_data, marked by rsp_valid for
// one cycle; the receiver cannot hold results off and needs none to.
// After acceptance a pixel passes three front stages, the 44 register
// stages of the pipelined restoring dividers for x, y and z, one queue
// stage and three back stages before the result is taken.
// Throughput is one pixel per cycle. busy is high during reset and until
// a register set by reset is cleared at the first edge without reset.
// Camera coordinates are computed in the front pipeline, pass a short queue,
// and are rotated, translated, rounded and saturated in the back pipeline.
// Registers are written through csr_we, csr_addr and csr_wdata with no
// wait state; the user must change them only while no transaction is in
// flight, which the block does not enforce. Reset loads the register
// defaults (identity pose) and drops all pixels in flight.
module depth_pixel_backprojection
   import dpb_pkg::*;
#(
   parameter int COORD_FRAC_BITS = DPB_COORD_FRAC_BITS,
   parameter int QUEUE_DEPTH = DPB_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0] depth_scale_ff, depth_scale_in;
   logic [15:0] max_depth_ff, max_depth_in;
   logic [39:0] focal_ff, focal_in;
   logic [39:0] center_ff, center_in;
   logic [53:0] rot0_ff, rot0_in;
   logic [53:0] rot1_ff, rot1_in;
   logic [53:0] rot2_ff, rot2_in;
   logic [59:0] trans_ff, trans_in;
   logic        busy_ff;

   cfg_type     cfg;
   logic        accept;
   logic        front_valid;
   cam_type     front_cam;
   logic        queue_valid;
   cam_type     queue_cam;

   always_comb begin
      depth_scale_in = depth_scale_ff;
      max_depth_in = max_depth_ff;
      focal_in = focal_ff;
      center_in = center_ff;
      rot0_in = rot0_ff;
      rot1_in = rot1_ff;
      rot2_in = rot2_ff;
      trans_in = trans_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_DEPTH_SCALE: begin
               depth_scale_in = csr_wdata[15:0];
            end
            REG_MAX_DEPTH: begin
               max_depth_in = csr_wdata[15:0];
            end
            REG_FOCAL_LENGTHS: begin
               focal_in = csr_wdata[39:0];
            end
            REG_OPTICAL_CENTER: begin
               center_in = csr_wdata[39:0];
            end
            REG_ROTATION_ROW0: begin
               rot0_in = csr_wdata[53:0];
            end
            REG_ROTATION_ROW1: begin
               rot1_in = csr_wdata[53:0];
            end
            REG_ROTATION_ROW2: begin
               rot2_in = csr_wdata[53:0];
            end
            REG_TRANSLATION: begin
               trans_in = csr_wdata[59:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= RST_DEPTH_SCALE;
         max_depth_ff <= RST_MAX_DEPTH;
         focal_ff <= RST_FOCAL_LENGTHS;
         center_ff <= RST_OPTICAL_CENTER;
         rot0_ff <= RST_ROTATION_ROW0;
         rot1_ff <= RST_ROTATION_ROW1;
         rot2_ff <= RST_ROTATION_ROW2;
         trans_ff <= RST_TRANSLATION;
         busy_ff <= 1'b1;
      end else begin
         depth_scale_ff <= depth_scale_in;
         max_depth_ff <= max_depth_in;
         focal_ff <= focal_in;
         center_ff <= center_in;
         rot0_ff <= rot0_in;
         rot1_ff <= rot1_in;
         rot2_ff <= rot2_in;
         trans_ff <= trans_in;
         busy_ff <= 1'b0;
      end
   end

   assign cfg.depth_scale = depth_scale_ff;
   assign cfg.max_depth = max_depth_ff;
   assign cfg.fx = focal_ff[19:0];
   assign cfg.fy = focal_ff[39:20];
   assign cfg.cx = center_ff[19:0];
   assign cfg.cy = center_ff[39:20];
   assign cfg.rot[0] = rot0_ff;
   assign cfg.rot[1] = rot1_ff;
   assign cfg.rot[2] = rot2_ff;
   assign cfg.trans = trans_ff;

   assign busy = busy_ff | reset;
   assign accept = start && !busy;

   dpb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_data),
      .cfg      (cfg),
      .out_valid(front_valid),
      .out_cam  (front_cam)
   );

   dpb_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_data(front_cam),
      .pop      (queue_valid),
      .out_valid(queue_valid),
      .out_data (queue_cam)
   );

   dpb_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_cam   (queue_cam),
      .cfg      (cfg),
      .out_valid(rsp_valid),
      .out_rsp  (rsp_data)
   );

endmodule

// ===== hw/rtl/dpb_div.sv =====
module dpb_div
   import dpb_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W,
   parameter int Q_W = DIV_Q_W,
   parameter int SIDE_W = DIV_SIDE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   logic [Q_W:0]        vld_ff, vld_in;
   logic [Q_W:0]        ovf_ff, ovf_in;
   logic [DEN_W-1:0]    rem_ff [Q_W+1];
   logic [DEN_W-1:0]    rem_in [Q_W+1];
   logic [DEN_W-1:0]    den_ff [Q_W+1];
   logic [DEN_W-1:0]    den_in [Q_W+1];
   logic [Q_W-1:0]      nlo_ff [Q_W+1];
   logic [Q_W-1:0]      nlo_in [Q_W+1];
   logic [Q_W-1:0]      quot_ff [Q_W+1];
   logic [Q_W-1:0]      quot_in [Q_W+1];
   logic [SIDE_W-1:0]   side_ff [Q_W+1];
   logic [SIDE_W-1:0]   side_in [Q_W+1];

   always_comb begin
      logic [DEN_W-1:0] head;
      logic [DEN_W:0]   trial;
      logic             fits;
      head = DEN_W'(in_num[NUM_W-1:Q_W]);
      vld_in[0] = in_valid;
      ovf_in[0] = head >= in_den;
      rem_in[0] = (head >= in_den) ? '0 : head;
      den_in[0] = in_den;
      nlo_in[0] = in_num[Q_W-1:0];
      quot_in[0] = '0;
      side_in[0] = in_side;
      for (int i = 1; i <= Q_W; i++) begin
         trial = {rem_ff[i-1], nlo_ff[i-1][Q_W-1]};
         fits = trial >= {1'b0, den_ff[i-1]};
         vld_in[i] = vld_ff[i-1];
         ovf_in[i] = ovf_ff[i-1];
         rem_in[i] = fits ? DEN_W'(trial - {1'b0, den_ff[i-1]}) : trial[DEN_W-1:0];
         den_in[i] = den_ff[i-1];
         nlo_in[i] = nlo_ff[i-1] << 1;
         quot_in[i] = {quot_ff[i-1][Q_W-2:0], fits};
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      nlo_ff <= nlo_in;
      quot_ff <= quot_in;
      side_ff <= side_in;
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quot = quot_ff[Q_W];
   assign out_ovf = ovf_ff[Q_W];
   assign out_side = side_ff[Q_W];

endmodule

// ===== hw/rtl/dpb_front.sv =====
module dpb_front
   import dpb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   input  cfg_type cfg,
   output logic    out_valid,
   output cam_type out_cam
);

   logic                s0_vld_ff, s0_vld_in;
   req_type             s0_req_ff, s0_req_in;

   logic                s1_vld_ff, s1_vld_in;
   logic signed [20:0]  s1_du_ff, s1_du_in;
   logic signed [20:0]  s1_dv_ff, s1_dv_in;
   logic [15:0]         s1_depth_ff, s1_depth_in;
   logic [15:0]         s1_scale_ff, s1_scale_in;
   logic [19:0]         s1_fx_ff, s1_fx_in;
   logic [19:0]         s1_fy_ff, s1_fy_in;
   logic                s1_pv_ff, s1_pv_in;
   logic                s1_fe_ff, s1_fe_in;

   logic                s2_vld_ff, s2_vld_in;
   logic [35:0]         s2_px_ff, s2_px_in;
   logic [35:0]         s2_py_ff, s2_py_in;
   logic [35:0]         s2_denx_ff, s2_denx_in;
   logic [35:0]         s2_deny_ff, s2_deny_in;
   logic [15:0]         s2_depth_ff, s2_depth_in;
   logic [15:0]         s2_scale_ff, s2_scale_in;
   logic                s2_negx_ff, s2_negx_in;
   logic                s2_negy_ff, s2_negy_in;
   logic                s2_zerox_ff, s2_zerox_in;
   logic                s2_zeroy_ff, s2_zeroy_in;
   logic                s2_pv_ff, s2_pv_in;
   logic                s2_fe_ff, s2_fe_in;

   logic [DIV_NUM_W-1:0]  num_x, num_y, num_z;
   logic                  vx, vy, vz;
   logic [DIV_Q_W-1:0]    qx, qy, qz;
   logic                  ox, oy, oz;
   logic [DIV_SIDE_W-1:0] sdx, sdy, sdz;

   function automatic logic signed [CAM_W-1:0] to_cam(logic [DIV_Q_W-1:0] q, logic ovf,
                                                      logic neg, logic zero);
      logic [DIV_Q_W-1:0] mag;
      logic [CAM_W-1:0]   ext;
      mag = (ovf || (q > CAM_LIMIT)) ? CAM_LIMIT : q;
      ext = {1'b0, mag};
      if (zero) begin
         return '0;
      end else if (neg) begin
         return CAM_W'(-ext);
      end
      return ext;
   endfunction

   always_comb begin
      logic [20:0] ndu;
      logic [20:0] ndv;
      logic [19:0] adu;
      logic [19:0] adv;
      s0_vld_in = in_valid;
      s0_req_in = in_req;

      s1_vld_in = s0_vld_ff;
      s1_du_in = $signed({1'b0, s0_req_ff.pixel_col, 8'b0}) - $signed({1'b0, cfg.cx});
      s1_dv_in = $signed({1'b0, s0_req_ff.pixel_row, 8'b0}) - $signed({1'b0, cfg.cy});
      s1_depth_in = s0_req_ff.raw_depth;
      s1_scale_in = (cfg.depth_scale == 16'd0) ? 16'd1 : cfg.depth_scale;
      s1_fx_in = cfg.fx;
      s1_fy_in = cfg.fy;
      s1_pv_in = (s0_req_ff.raw_depth != 16'd0) && (s0_req_ff.raw_depth < cfg.max_depth);
      s1_fe_in = s0_req_ff.frame_end;

      ndu = 21'(-s1_du_ff);
      ndv = 21'(-s1_dv_ff);
      adu = s1_du_ff[20] ? ndu[19:0] : s1_du_ff[19:0];
      adv = s1_dv_ff[20] ? ndv[19:0] : s1_dv_ff[19:0];
      s2_vld_in = s1_vld_ff;
      s2_px_in = 36'(adu) * 36'(s1_depth_ff);
      s2_py_in = 36'(adv) * 36'(s1_depth_ff);
      s2_denx_in = 36'(s1_scale_ff) * 36'(s1_fx_ff);
      s2_deny_in = 36'(s1_scale_ff) * 36'(s1_fy_ff);
      s2_depth_in = s1_depth_ff;
      s2_scale_in = s1_scale_ff;
      s2_negx_in = s1_du_ff[20];
      s2_negy_in = s1_dv_ff[20];
      s2_zerox_in = s1_fx_ff == 20'd0;
      s2_zeroy_in = s1_fy_ff == 20'd0;
      s2_pv_in = s1_pv_ff;
      s2_fe_in = s1_fe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= s0_vld_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
      s0_req_ff <= s0_req_in;
      s1_du_ff <= s1_du_in;
      s1_dv_ff <= s1_dv_in;
      s1_depth_ff <= s1_depth_in;
      s1_scale_ff <= s1_scale_in;
      s1_fx_ff <= s1_fx_in;
      s1_fy_ff <= s1_fy_in;
      s1_pv_ff <= s1_pv_in;
      s1_fe_ff <= s1_fe_in;
      s2_px_ff <= s2_px_in;
      s2_py_ff <= s2_py_in;
      s2_denx_ff <= s2_denx_in;
      s2_deny_ff <= s2_deny_in;
      s2_depth_ff <= s2_depth_in;
      s2_scale_ff <= s2_scale_in;
      s2_negx_ff <= s2_negx_in;
      s2_negy_ff <= s2_negy_in;
      s2_zerox_ff <= s2_zerox_in;
      s2_zeroy_ff <= s2_zeroy_in;
      s2_pv_ff <= s2_pv_in;
      s2_fe_ff <= s2_fe_in;
   end

   assign num_x = DIV_NUM_W'({s2_px_ff, 16'b0}) + DIV_NUM_W'(s2_denx_ff >> 1);
   assign num_y = DIV_NUM_W'({s2_py_ff, 16'b0}) + DIV_NUM_W'(s2_deny_ff >> 1);
   assign num_z = DIV_NUM_W'({s2_depth_ff, 16'b0}) + DIV_NUM_W'(s2_scale_ff >> 1);

   dpb_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_vld_ff),
      .in_num   (num_x),
      .in_den   (s2_denx_ff),
      .in_side  ({s2_negx_ff, s2_zerox_ff}),
      .out_valid(vx),
      .out_quot (qx),
      .out_ovf  (ox),
      .out_side (sdx)
   );

   dpb_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_vld_ff),
      .in_num   (num_y),
      .in_den   (s2_deny_ff),
      .in_side  ({s2_negy_ff, s2_zeroy_ff}),
      .out_valid(vy),
      .out_quot (qy),
      .out_ovf  (oy),
      .out_side (sdy)
   );

   dpb_div u_div_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_vld_ff),
      .in_num   (num_z),
      .in_den   (DIV_DEN_W'(s2_scale_ff)),
      .in_side  ({s2_pv_ff, s2_fe_ff}),
      .out_valid(vz),
      .out_quot (qz),
      .out_ovf  (oz),
      .out_side (sdz)
   );

   assign out_valid = vx & vy & vz;
   assign out_cam.cam_x = to_cam(qx, ox, sdx[1], sdx[0]);
   assign out_cam.cam_y = to_cam(qy, oy, sdy[1], sdy[0]);
   assign out_cam.cam_z = to_cam(qz, oz, 1'b0, 1'b0);
   assign out_cam.point_valid = sdz[1];
   assign out_cam.last_point = sdz[0];

endmodule

// ===== hw/rtl/dpb_queue.sv =====
module dpb_queue
   import dpb_pkg::*;
#(
   parameter int DEPTH = DPB_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cam_type push_data,
   input  logic    pop,
   output logic    out_valid,
   output cam_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cam_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign do_push = push && ((count_ff != CNT_W'(DEPTH)) || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data = mem_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/dpb_back.sv =====
module dpb_back
   import dpb_pkg::*;
#(
   parameter int COORD_FRAC_BITS = DPB_COORD_FRAC_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cam_type in_cam,
   input  cfg_type cfg,
   output logic    out_valid,
   output rsp_type out_rsp
);

   localparam int SHIFT = 32 - COORD_FRAC_BITS;
   localparam logic signed [63:0] RND = 64'sd1 <<< (SHIFT - 1);
   localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

   logic                     b1_vld_ff, b1_vld_in;
   logic signed [61:0]       prod_ff [3][3];
   logic signed [61:0]       prod_in [3][3];
   logic                     b1_pv_ff, b1_pv_in;
   logic                     b1_fe_ff, b1_fe_in;

   logic                     b2_vld_ff, b2_vld_in;
   logic signed [63:0]       sum_ff [3];
   logic signed [63:0]       sum_in [3];
   logic                     b2_pv_ff, b2_pv_in;
   logic                     b2_fe_ff, b2_fe_in;

   logic                     b3_vld_ff, b3_vld_in;
   logic signed [31:0]       coord_ff [3];
   logic signed [31:0]       coord_in [3];
   logic                     b3_pv_ff, b3_pv_in;
   logic                     b3_fe_ff, b3_fe_in;

   always_comb begin
      logic signed [CAM_W-1:0] cam [3];
      logic signed [17:0]      rot;
      logic signed [63:0]      rnd;
      cam[0] = in_cam.cam_x;
      cam[1] = in_cam.cam_y;
      cam[2] = in_cam.cam_z;
      b1_vld_in = in_valid;
      b1_pv_in = in_cam.point_valid;
      b1_fe_in = in_cam.last_point;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            rot = $signed(cfg.rot[i][k]);
            prod_in[i][k] = rot * cam[k];
         end
      end

      b2_vld_in = b1_vld_ff;
      b2_pv_in = b1_pv_ff;
      b2_fe_in = b1_fe_ff;
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2]
                   + $signed({{24{cfg.trans[i][19]}}, cfg.trans[i], 20'b0});
      end

      b3_vld_in = b2_vld_ff;
      b3_pv_in = b2_pv_ff;
      b3_fe_in = b2_fe_ff;
      for (int i = 0; i < 3; i++) begin
         rnd = (sum_ff[i] + RND) >>> SHIFT;
         if (!b2_pv_ff) begin
            coord_in[i] = '0;
         end else if (rnd > OUT_MAX) begin
            coord_in[i] = 32'sh7fffffff;
         end else if (rnd < OUT_MIN) begin
            coord_in[i] = 32'sh80000000;
         end else begin
            coord_in[i] = rnd[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
      end else begin
         b1_vld_ff <= b1_vld_in;
         b2_vld_ff <= b2_vld_in;
         b3_vld_ff <= b3_vld_in;
      end
      prod_ff <= prod_in;
      b1_pv_ff <= b1_pv_in;
      b1_fe_ff <= b1_fe_in;
      sum_ff <= sum_in;
      b2_pv_ff <= b2_pv_in;
      b2_fe_ff <= b2_fe_in;
      coord_ff <= coord_in;
      b3_pv_ff <= b3_pv_in;
      b3_fe_ff <= b3_fe_in;
   end

   assign out_valid = b3_vld_ff;
   assign out_rsp.world_x = coord_ff[0];
   assign out_rsp.world_y = coord_ff[1];
   assign out_rsp.world_z = coord_ff[2];
   assign out_rsp.point_valid = b3_pv_ff;
   assign out_rsp.last_point = b3_fe_ff;

endmodule

// ===== hw/rtl/dpb_checker.sv =====
`include "depth_pixel_backprojection_defines.svh"

module dpb_checker
   import dpb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input req_type               req_data,
   input logic                  rsp_valid,
   input rsp_type               rsp_data,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   logic csr_seen;

   assign csr_seen = csr_we && (csr_addr == REG_DEPTH_SCALE) && (csr_wdata == '0);

   `DPB_ASSERT_DELAY(a_result_follows, clock, reset, start && !busy, DPB_LATENCY, rsp_valid)
   `DPB_ASSERT_IMP(a_result_has_cause, clock, reset, rsp_valid, $past(start && !busy, DPB_LATENCY))
   `DPB_ASSERT_IMP(a_invalid_is_zero, clock, reset, rsp_valid && !rsp_data.point_valid, (rsp_data.world_x == 0) && (rsp_data.world_y == 0) && (rsp_data.world_z == 0))
   `DPB_ASSERT_IMP(a_zero_depth_rejected, clock, reset || csr_seen, rsp_valid && rsp_data.point_valid, $past(req_data.raw_depth != 16'd0, DPB_LATENCY))

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import dpb_pkg::*;

   localparam int LATENCY = DPB_LATENCY;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint CAM_CLAMP = 64'sd1 << 42;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [15:0] depth_scale;
   logic [15:0] max_depth;
   logic [39:0] focal_lengths;
   logic [39:0] optical_center;
   logic [53:0] rotation_row [3];
   logic [59:0] translation;

   rsp_type expected_points [$];
   int      mismatch_count;
   int      idle_cycles;
   int      send_idle_pct;

   depth_pixel_backprojection uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint round_div_clamp(longint num, longint den);
      logic    neg;
      longint  mag;
      longint  quot;
      neg = num < 0;
      mag = neg ? -num : num;
      quot = (mag + den / 2) / den;
      if (quot > CAM_CLAMP) begin
         quot = CAM_CLAMP;
      end
      return neg ? -quot : quot;
   endfunction

   function automatic logic signed [31:0] round_saturate(logic signed [127:0] acc);
      logic signed [127:0] r;
      r = (acc + (128'sd1 <<< (31 - DPB_COORD_FRAC_BITS))) >>> (32 - DPB_COORD_FRAC_BITS);
      if (r > 128'sd2147483647) begin
         r = 128'sd2147483647;
      end
      if (r < -128'sd2147483648) begin
         r = -128'sd2147483648;
      end
      return r[31:0];
   endfunction

   function automatic rsp_type project_pixel(req_type px);
      rsp_type             pt;
      longint              scale;
      longint              fx;
      longint              fy;
      longint              du;
      longint              dv;
      longint              num;
      longint              cam [3];
      logic signed [127:0] acc;
      logic signed [127:0] prod;
      logic signed [17:0]  coef;
      logic signed [19:0]  shift;
      logic signed [31:0]  world [3];
      pt = '0;
      pt.last_point = px.frame_end;
      if (px.raw_depth == 0 || px.raw_depth >= max_depth) begin
         return pt;
      end
      scale = (depth_scale == 0) ? 1 : longint'(depth_scale);
      fx = longint'(focal_lengths[19:0]);
      fy = longint'(focal_lengths[39:20]);
      du = longint'(px.pixel_col) * 256 - longint'(optical_center[19:0]);
      dv = longint'(px.pixel_row) * 256 - longint'(optical_center[39:20]);
      num = longint'(px.raw_depth) <<< 16;
      cam[2] = round_div_clamp(num, scale);
      cam[0] = (fx != 0) ? round_div_clamp(du * num, scale * fx) : 0;
      cam[1] = (fy != 0) ? round_div_clamp(dv * num, scale * fy) : 0;
      for (int i = 0; i < 3; i++) begin
         shift = translation[20*i +: 20];
         acc = 128'(shift) <<< 20;
         for (int k = 0; k < 3; k++) begin
            coef = rotation_row[i][18*k +: 18];
            prod = 128'(coef) * 128'(cam[k]);
            acc = acc + prod;
         end
         world[i] = round_saturate(acc);
      end
      pt.world_x = world[0];
      pt.world_y = world[1];
      pt.world_z = world[2];
      pt.point_valid = 1'b1;
      return pt;
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected transaction", 128'(rsp_data), 128'd0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.world_x !== want.world_x) begin
                  report_mismatch("world_x", rsp_data.world_x, want.world_x);
               end
               if (rsp_data.world_y !== want.world_y) begin
                  report_mismatch("world_y", rsp_data.world_y, want.world_y);
               end
               if (rsp_data.world_z !== want.world_z) begin
                  report_mismatch("world_z", rsp_data.world_z, want.world_z);
               end
               if (rsp_data.point_valid !== want.point_valid) begin
                  report_mismatch("point_valid", rsp_data.point_valid, want.point_valid);
               end
               if (rsp_data.last_point !== want.last_point) begin
                  report_mismatch("last_point", rsp_data.last_point, want.last_point);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   task automatic drain_points();
      while (expected_points.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] index, logic [59:0] value);
      csr_we = 1'b1;
      csr_addr = index;
      csr_wdata = value;
      case (index)
         REG_DEPTH_SCALE: begin
            depth_scale = value[15:0];
         end
         REG_MAX_DEPTH: begin
            max_depth = value[15:0];
         end
         REG_FOCAL_LENGTHS: begin
            focal_lengths = value[39:0];
         end
         REG_OPTICAL_CENTER: begin
            optical_center = value[39:0];
         end
         REG_ROTATION_ROW0: begin
            rotation_row[0] = value[53:0];
         end
         REG_ROTATION_ROW1: begin
            rotation_row[1] = value[53:0];
         end
         REG_ROTATION_ROW2: begin
            rotation_row[2] = value[53:0];
         end
         REG_TRANSLATION: begin
            translation = value[59:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_pixel(req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = px;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      expected_points = {expected_points, project_pixel(px)};
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic req_type random_pixel();
      req_type px;
      px.pixel_col = 12'($urandom_range(4095));
      px.pixel_row = 12'($urandom_range(4095));
      case ($urandom_range(9))
         0: begin
            px.raw_depth = 16'd0;
         end
         1: begin
            px.raw_depth = 16'($urandom_range(65535));
         end
         2: begin
            px.raw_depth = max_depth;
         end
         default: begin
            px.raw_depth = (max_depth > 1) ? 16'($urandom_range(max_depth - 1, 1)) : 16'd1;
         end
      endcase
      px.frame_end = ($urandom_range(15) == 0);
      return px;
   endfunction

   function automatic logic [53:0] random_rotation_row();
      logic [53:0] row;
      row = 54'({$urandom, $urandom});
      if ($urandom_range(1)) begin
         for (int k = 0; k < 3; k++) begin
            row[18*k +: 18] = 18'($signed($urandom_range(131072)) - 65536);
         end
      end
      return row;
   endfunction

   task automatic load_random_pose();
      write_register(REG_DEPTH_SCALE,
                     60'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(8000, 200)));
      write_register(REG_MAX_DEPTH, 60'($urandom_range(65535, 1)));
      write_register(REG_FOCAL_LENGTHS, 60'({$urandom, $urandom}));
      write_register(REG_OPTICAL_CENTER, 60'({$urandom, $urandom}));
      write_register(REG_ROTATION_ROW0, 60'(random_rotation_row()));
      write_register(REG_ROTATION_ROW1, 60'(random_rotation_row()));
      write_register(REG_ROTATION_ROW2, 60'(random_rotation_row()));
      write_register(REG_TRANSLATION, 60'({$urandom, $urandom}));
   endtask

   task automatic test_default_pose();
      req_type px;
      int      depths [8] = '{0, 1, 6999, 7000, 65535, 5000, 2500, 3};
      for (int i = 0; i < 8; i++) begin
         px.pixel_col = (i % 2) ? 12'hFFF : 12'h000;
         px.pixel_row = (i % 3) ? 12'hFFF : 12'h000;
         px.raw_depth = 16'(depths[i]);
         px.frame_end = i[0];
         send_pixel(px);
      end
      drain_points();
   endtask

   task automatic test_extreme_registers();
      req_type px;
      write_register(REG_DEPTH_SCALE, 60'd0);
      write_register(REG_MAX_DEPTH, 60'd65535);
      write_register(REG_FOCAL_LENGTHS, 60'({20'd0, 20'd1}));
      write_register(REG_OPTICAL_CENTER, 60'({20'hFFFFF, 20'h00000}));
      write_register(REG_ROTATION_ROW0, 60'({18'h20000, 18'h1FFFF, 18'h20000}));
      write_register(REG_ROTATION_ROW1, 60'({18'h1FFFF, 18'h20000, 18'h1FFFF}));
      write_register(REG_ROTATION_ROW2, 60'({54{1'b1}}));
      write_register(REG_TRANSLATION, {20'h80000, 20'h7FFFF, 20'hFFFFF});
      write_register(3'(REG_TRANSLATION + 1), 60'd0);
      for (int i = 0; i < 8; i++) begin
         px.pixel_col = i[0] ? 12'hFFF : 12'h000;
         px.pixel_row = i[1] ? 12'hFFF : 12'h000;
         px.raw_depth = i[2] ? 16'hFFFE : 16'h0001;
         px.frame_end = i[0];
         send_pixel(px);
      end
      drain_points();
      write_register(REG_DEPTH_SCALE, 60'd65535);
      write_register(REG_MAX_DEPTH, 60'd1);
      write_register(REG_FOCAL_LENGTHS, 60'({40{1'b1}}));
      write_register(REG_OPTICAL_CENTER, 60'd0);
      for (int i = 0; i < 4; i++) begin
         px = random_pixel();
         px.raw_depth = 16'(i);
         send_pixel(px);
      end
      drain_points();
   endtask

   task automatic test_random_pixels(int count, int idle_pct);
      send_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            drain_points();
            load_random_pose();
         end
         send_pixel(random_pixel());
      end
      drain_points();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      depth_scale = RST_DEPTH_SCALE;
      max_depth = RST_MAX_DEPTH;
      focal_lengths = RST_FOCAL_LENGTHS;
      optical_center = RST_OPTICAL_CENTER;
      rotation_row[0] = RST_ROTATION_ROW0;
      rotation_row[1] = RST_ROTATION_ROW1;
      rotation_row[2] = RST_ROTATION_ROW2;
      translation = RST_TRANSLATION;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_pose();
      test_extreme_registers();
      test_random_pixels(500, 12);
      test_random_pixels(500, 56);
      test_random_pixels(500, 0);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
